FILE: src/swoc_pkg.sv
// Shared constants and types for the sliding window outcome counter.
// No dependencies; imported by the top level.
`default_nettype none
package swoc_pkg;
	localparam int MAX_WINDOW_DEF = 1024;
	localparam int LEN_W          = 11;
	localparam int TALLY_W        = 11;
	localparam int FRAC_W         = 16;
	localparam int RATE_W         = FRAC_W + 1;
	localparam int IN_TDATA_W     = 8;
	localparam int OUT_FIELDS_W   = 2 * TALLY_W + 2 + RATE_W;
	localparam int OUT_TDATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;

	typedef enum logic {
		OP_RECORD = 1'b0,
		OP_CLEAR  = 1'b1
	} op_t;
endpackage
`default_nettype wire

FILE: src/swoc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module swoc_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1024,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

FILE: src/sliding_window_outcome_counter.sv
// Sliding window pass/fail counter: ring of outcome bits in RAM, tallies and
// a radix-2 divider for the pass rate. Depends on swoc_pkg and swoc_ram.
//
// Each request on the slave stream (tuser = op: record or clear, tdata bit 0 =
// outcome) yields one result on the master stream holding the pass and fail
// tallies of the last window_length outcomes, full and empty flags and the pass
// rate as truncated unsigned Q1.16 (0 when the window is empty). For a record
// request the ring RAM read is issued at the accepting edge, then ST_UPD does
// the tally update and write-back, ST_DIV runs the bit-per-cycle restoring
// divider, and ST_FIN loads the output register. A clear request skips ST_UPD.
// The block takes a new request only in idle, so not while one is in flight;
// ST_FIN holds the result back while the previous one still waits for the
// sink. A write on cfg_wen sets window_length (zero is ignored, values above
// MAX_WINDOW are clamped) and clears the tallies and the cursor; write it only
// while no request is in flight.
`default_nettype none
module sliding_window_outcome_counter
	import swoc_pkg::*;
#(
	parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [0] outcome, rest zero
	input  wire logic [0:0]             s_axis_tuser,  // [0] op
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	// [10:0] pass_tally, [21:11] fail_tally, [22] window_full,
	// [23] window_empty, [40:24] pass_rate, rest zero
	output logic      [OUT_TDATA_W-1:0] m_axis_tdata,
	input  wire logic                   cfg_wen,
	input  wire logic [LEN_W-1:0]       cfg_wdata
);
	localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
	localparam int CUR_W  = $clog2(MAX_WINDOW);
	localparam int EXT_W  = (CNT_W > LEN_W) ? CNT_W : LEN_W;
	localparam int STEP_W = $clog2(RATE_W);
	localparam logic [EXT_W-1:0] MAX_EXT = EXT_W'(MAX_WINDOW);
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_WINDOW);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPD,
		ST_DIV,
		ST_FIN
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    len_q;
	logic [CUR_W-1:0]    cursor_q;
	logic [CNT_W-1:0]    pass_q;
	logic [CNT_W-1:0]    fail_q;
	logic                outcome_q;
	logic [CNT_W:0]      rem_q;
	logic [RATE_W-1:0]   quo_q;
	logic [STEP_W-1:0]   step_q;
	logic                out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;

	logic                in_acc;
	logic [CNT_W-1:0]    pos_ext;
	logic [CNT_W-1:0]    pos_next;
	logic [CUR_W-1:0]    pos;
	logic                old_bit;
	logic [CNT_W-1:0]    total;
	logic                is_full;
	logic [CNT_W-1:0]    pass_n;
	logic [CNT_W-1:0]    fail_n;
	logic [CNT_W:0]      rem_diff;
	logic                quo_bit;
	logic [EXT_W-1:0]    cfg_ext;
	logic [EXT_W-1:0]    cfg_clamped;
	logic [EXT_W-1:0]    pass_ext;
	logic [EXT_W-1:0]    fail_ext;
	logic [RATE_W-1:0]   rate;
	logic [OUT_FIELDS_W-1:0] fields;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// Guard a cursor that somehow sits past the ring.
	always_comb begin
		pos_ext = CNT_W'(cursor_q);
		if (pos_ext >= MAX_CNT) begin
			pos_ext = '0;
		end
		pos      = pos_ext[CUR_W-1:0];
		pos_next = pos_ext + CNT_W'(1);
		if (pos_next == len_q) begin
			pos_next = '0;
		end
	end

	swoc_ram #(
		.WIDTH(1),
		.DEPTH(MAX_WINDOW),
		.ADDR_W(CUR_W)
	) u_ring (
		.clk  (clk),
		.we   (state_q == ST_UPD),
		.waddr(pos),
		.wdata(outcome_q),
		.raddr(pos),
		.rdata(old_bit)
	);

	assign total   = pass_q + fail_q;
	assign is_full = (total == len_q);

	// Tally update: grow while filling, move one count when a full window flips.
	always_comb begin
		pass_n = pass_q;
		fail_n = fail_q;
		if (!is_full) begin
			if (outcome_q) begin
				pass_n = pass_q + CNT_W'(1);
			end else begin
				fail_n = fail_q + CNT_W'(1);
			end
		end else if (old_bit != outcome_q) begin
			if (outcome_q) begin
				pass_n = pass_q + CNT_W'(1);
				fail_n = fail_q - CNT_W'(1);
			end else begin
				pass_n = pass_q - CNT_W'(1);
				fail_n = fail_q + CNT_W'(1);
			end
		end
	end

	assign rem_diff = rem_q - {1'b0, total};
	assign quo_bit  = (rem_q >= {1'b0, total});

	always_comb begin
		cfg_ext     = EXT_W'(cfg_wdata);
		cfg_clamped = (cfg_ext > MAX_EXT) ? MAX_EXT : cfg_ext;
		pass_ext    = EXT_W'(pass_q);
		fail_ext    = EXT_W'(fail_q);
		rate        = (total == '0) ? '0 : quo_q;
		fields      = {rate, (total == '0), is_full,
			fail_ext[TALLY_W-1:0], pass_ext[TALLY_W-1:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			len_q       <= MAX_CNT;
			cursor_q    <= '0;
			pass_q      <= '0;
			fail_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// ST_FIN either reloads the output register or leaves it untouched
			if (out_valid_q && m_axis_tready && (state_q != ST_FIN)) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wen && (cfg_wdata != '0)) begin
				len_q    <= cfg_clamped[CNT_W-1:0];
				cursor_q <= '0;
				pass_q   <= '0;
				fail_q   <= '0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						outcome_q <= s_axis_tdata[0];
						if (op_t'(s_axis_tuser[0]) == OP_CLEAR) begin
							cursor_q <= '0;
							pass_q   <= '0;
							fail_q   <= '0;
							rem_q    <= '0;
							step_q   <= STEP_W'(RATE_W - 1);
							state_q  <= ST_DIV;
						end else begin
							state_q <= ST_UPD;
						end
					end
				end
				ST_UPD: begin
					pass_q   <= pass_n;
					fail_q   <= fail_n;
					cursor_q <= pos_next[CUR_W-1:0];
					rem_q    <= {1'b0, pass_n};
					step_q   <= STEP_W'(RATE_W - 1);
					state_q  <= ST_DIV;
				end
				ST_DIV: begin
					// Remainder stays below the divisor, so the shift cannot overflow.
					if (quo_bit) begin
						rem_q <= {rem_diff[CNT_W-1:0], 1'b0};
					end else begin
						rem_q <= {rem_q[CNT_W-1:0], 1'b0};
					end
					quo_q <= {quo_q[RATE_W-2:0], quo_bit};
					if (step_q == '0) begin
						state_q <= ST_FIN;
					end else begin
						step_q <= step_q - STEP_W'(1);
					end
				end
				ST_FIN: begin
					// Hold until the previous result has left the output register.
					if (!out_valid_q || m_axis_tready) begin
						out_data_q  <= OUT_TDATA_W'(fields);
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: tb/sv/swoc_tally_checker.sv
// Checker for the sliding window outcome counter: tracks the outcome ring,
// cursor and tallies from accepted requests and compares every result.
// Depends on swoc_pkg; instantiated beside the block by the testbench top.
`default_nettype none
module swoc_tally_checker
	import swoc_pkg::*;
#(
	parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	input  wire logic                   s_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // [0] outcome, rest zero
	input  wire logic [0:0]             s_tuser,   // [0] op
	input  wire logic                   m_tvalid,
	input  wire logic                   m_tready,
	// [10:0] pass_tally, [21:11] fail_tally, [22] window_full,
	// [23] window_empty, [40:24] pass_rate, rest zero
	input  wire logic [OUT_TDATA_W-1:0] m_tdata,
	input  wire logic                   cfg_wen,
	input  wire logic [LEN_W-1:0]       cfg_wdata,
	output int                          readings_owed,
	output int                          mismatch_count
);
	typedef struct packed {
		logic [TALLY_W-1:0] pass_tally;
		logic [TALLY_W-1:0] fail_tally;
		logic               window_full;
		logic               window_empty;
		logic [RATE_W-1:0]  pass_rate;
	} reading_t;

	bit          ring [MAX_WINDOW];
	int unsigned cursor;
	int unsigned passes;
	int unsigned fails;
	int unsigned length;
	reading_t    window_readings [$];

	task automatic wipe_window();
		passes = 0;
		fails  = 0;
		cursor = 0;
		foreach (ring[i])
			ring[i] = 1'b0;
	endtask

	task automatic record_outcome(input bit pass);
		int unsigned pos;
		pos = (cursor >= MAX_WINDOW) ? 0 : cursor;
		if (passes + fails != length) begin
			ring[pos] = pass;
			if (pass)
				passes++;
			else
				fails++;
		end else if (ring[pos] != pass) begin
			// full window: the overwritten outcome moves one count across
			ring[pos] = pass;
			if (pass) begin
				passes++;
				fails--;
			end else begin
				fails++;
				passes--;
			end
		end
		cursor = (pos + 1) % length;
	endtask

	function automatic reading_t current_reading();
		reading_t    r;
		int unsigned total;
		total          = passes + fails;
		r.pass_tally   = passes[TALLY_W-1:0];
		r.fail_tally   = fails[TALLY_W-1:0];
		r.window_full  = (total == length);
		r.window_empty = (total == 0);
		r.pass_rate    = (total == 0) ? '0 : RATE_W'((passes << FRAC_W) / total);
		return r;
	endfunction

	task automatic compare_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		reading_t want;
		reading_t got;
		int unsigned len;
		if (!arst_n) begin
			length = MAX_WINDOW;
			wipe_window();
			window_readings.delete();
			mismatch_count = 0;
			readings_owed  = 0;
		end else begin
			if (cfg_wen && cfg_wdata != '0) begin
				len    = 32'(cfg_wdata);
				length = (len > MAX_WINDOW) ? MAX_WINDOW : len;
				wipe_window();
			end
			// check the result first: it belongs to an older request
			if (m_tvalid && m_tready) begin
				got.pass_tally   = m_tdata[TALLY_W-1:0];
				got.fail_tally   = m_tdata[2*TALLY_W-1:TALLY_W];
				got.window_full  = m_tdata[2*TALLY_W];
				got.window_empty = m_tdata[2*TALLY_W+1];
				got.pass_rate    = m_tdata[2*TALLY_W+2 +: RATE_W];
				if (window_readings.size() == 0) begin
					$display("%0t: unexpected result, expected none, got %h", $time, m_tdata);
					mismatch_count++;
				end else begin
					want = window_readings.pop_front();
					compare_field("pass_tally", 32'(want.pass_tally), 32'(got.pass_tally));
					compare_field("fail_tally", 32'(want.fail_tally), 32'(got.fail_tally));
					compare_field("window_full", 32'(want.window_full),
						32'(got.window_full));
					compare_field("window_empty", 32'(want.window_empty),
						32'(got.window_empty));
					compare_field("pass_rate", 32'(want.pass_rate), 32'(got.pass_rate));
				end
			end
			if (s_tvalid && s_tready) begin
				if (op_t'(s_tuser[0]) == OP_CLEAR)
					wipe_window();
				else
					record_outcome(s_tdata[0]);
				window_readings.push_back(current_reading());
			end
			readings_owed = window_readings.size();
		end
	end
endmodule
`default_nettype wire

FILE: tb/sv/sliding_window_outcome_counter_tb.sv
// Testbench top for the sliding window outcome counter: clock, reset, request
// and config stimulus, random backpressure and the verdict.
// Depends on swoc_pkg, sliding_window_outcome_counter and swoc_tally_checker.
`default_nettype none
module sliding_window_outcome_counter_tb;
	import swoc_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 25;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic [IN_TDATA_W-1:0]  s_tdata   = '0;
	logic [0:0]             s_tuser   = '0;
	logic                   m_tready  = 1'b0;
	logic                   cfg_wen   = 1'b0;
	logic [LEN_W-1:0]       cfg_wdata = '0;
	wire                    s_tready;
	wire                    m_tvalid;
	wire  [OUT_TDATA_W-1:0] m_tdata;
	bit                     steady    = 1'b0;
	int                     quiet_cycles = 0;
	int                     readings_owed;
	int                     mismatch_count;

	sliding_window_outcome_counter dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_tready),
		.s_axis_tdata  (s_tdata),
		.s_axis_tuser  (s_tuser),
		.m_axis_tvalid (m_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_tdata),
		.cfg_wen       (cfg_wen),
		.cfg_wdata     (cfg_wdata)
	);

	swoc_tally_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.cfg_wen        (cfg_wen),
		.cfg_wdata      (cfg_wdata),
		.readings_owed  (readings_owed),
		.mismatch_count (mismatch_count)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	always @(negedge clk) begin
		m_tready <= steady || ($urandom_range(0, 99) >= 25);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wen) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_request(input op_t op, input bit outcome);
		@(negedge clk);
		if (!steady && $urandom_range(0, 99) < 25) begin
			s_tvalid <= 1'b0;
			do @(negedge clk); while ($urandom_range(0, 99) < 25);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {{(IN_TDATA_W-1){1'b0}}, outcome};
		do @(posedge clk); while (!s_tready);
	endtask

	// hold the sender until every result has come back
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		wait (readings_owed == 0);
	endtask

	task automatic write_length(input logic [LEN_W-1:0] value);
		drain();
		repeat (4) @(negedge clk);
		cfg_wen   <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_wen   <= 1'b0;
	endtask

	task automatic run_phase(input int count, input int clear_pct, input int pass_pct,
			input bit calm);
		op_t op;
		steady = calm;
		repeat (count) begin
			if ($urandom_range(0, 99) < 2)
				drain();
			op = ($urandom_range(0, 99) < clear_pct) ? OP_CLEAR : OP_RECORD;
			send_request(op, $urandom_range(0, 99) < pass_pct);
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset length: clear with outcome set, both outcomes, clear again
		send_request(OP_CLEAR, 1'b1);
		send_request(OP_RECORD, 1'b1);
		send_request(OP_RECORD, 1'b0);
		send_request(OP_RECORD, 1'b0);
		send_request(OP_CLEAR, 1'b0);
		// one-deep window: full on every record, overwrite both ways
		write_length(LEN_W'(1));
		send_request(OP_RECORD, 1'b1);
		send_request(OP_RECORD, 1'b0);
		send_request(OP_RECORD, 1'b0);
		send_request(OP_RECORD, 1'b1);
		send_request(OP_CLEAR, 1'b1);
		write_length(LEN_W'(2));
		send_request(OP_RECORD, 1'b1);
		send_request(OP_RECORD, 1'b1);
		send_request(OP_RECORD, 1'b0);
		send_request(OP_RECORD, 1'b0);
		send_request(OP_RECORD, 1'b0);
		send_request(OP_RECORD, 1'b1);

		// all-ones write clamps to the maximum; a run of passes, then fails
		write_length('1);
		run_phase(50, 0, 100, 1'b0);
		run_phase(30, 0, 0, 1'b0);
		write_length(LEN_W'(3));
		run_phase(60, 5, $urandom_range(0, 100), 1'b0);
		write_length(LEN_W'(1));
		run_phase(50, 5, 50, 1'b0);
		// zero write is dropped: the one-deep window carries on
		write_length('0);
		run_phase(40, 5, 30, 1'b0);
		write_length(LEN_W'(17));
		run_phase(80, 3, $urandom_range(0, 100), 1'b1);
		write_length(LEN_W'(MAX_WINDOW_DEF));
		run_phase(40, 10, $urandom_range(0, 100), 1'b0);
		write_length(LEN_W'($urandom_range(1, 40)));
		run_phase(80, 3, $urandom_range(0, 100), 1'b0);
		write_length(LEN_W'(1500));
		run_phase(40, 5, 70, 1'b0);
		write_length(LEN_W'(2));
		run_phase(40, 30, 50, 1'b0);

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && readings_owed == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
`default_nettype wire
